// File: design/mme_pkg.sv
`default_nettype none
package mme_pkg;

  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DIM_W  = 4;
  localparam int unsigned PROD_W = 36;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } mme_op_e;

  typedef enum logic [1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_LEN = 2'd1,
    CFG_COLS_B    = 2'd2
  } mme_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } mme_state_e;

  // Tag that travels down the cell chain alongside a partial sum.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } mme_tok_t;

endpackage
`default_nettype wire

// File: design/mme_ram.sv
`default_nettype none
module mme_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: design/mme_cell.sv
`default_nettype none
module mme_cell
  import mme_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned ACC_W      = 35
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         active_i,
  input  wire logic signed [DATA_WIDTH-1:0] a_i,
  input  wire logic signed [DATA_WIDTH-1:0] b_i,
  input  wire mme_tok_t                     tok_i,
  input  wire logic signed [ACC_W-1:0]      acc_i,
  output mme_tok_t                          tok_o,
  output logic signed      [ACC_W-1:0]      acc_o
);

  mme_tok_t                  tok_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [2*DATA_WIDTH-1:0] prod;

  assign prod  = a_i * b_i;
  // Cells past the configured inner length only pass the sum along.
  assign acc_d = active_i ? acc_i + ACC_W'(prod) : acc_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (en_i) begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign tok_o = tok_q;
  assign acc_o = acc_q;

endmodule
`default_nettype wire

// File: design/matrix_multiply_engine.sv
// Matrix multiply engine, C = A x B on signed fixed-point operands.
// Input stream (s_axis): load items write one element of A or B; a compute
// item walks the configured sizes and emits C in row-major order on the
// output stream (m_axis), one item per element, tlast on the final one.
// Loads are taken one per cycle. After a compute item the input side holds
// tready low until the last result has been taken.
// The compute reads one A and one B element per cycle from the two stores
// and feeds a chain of MAX_DIM multiply-accumulate cells; the partial sum of
// one element steps one cell per cycle. Each element's terms are read in
// turn through the single read port of each store, so a new element starts
// only after the last term of the one before has been read.
// Configuration (rows_a, inner_len, cols_b) is written on the cfg channel,
// always ready, and must only change while the block is idle.
// Reset clears control state and sets all sizes to 8; the stores are not
// cleared and must be loaded before use.
// When the receiver stalls, the whole compute path (sequencer, store reads
// and cell chain) freezes; no result is lost.
`default_nettype none
module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned DATA_WIDTH = 16,
  localparam int unsigned IN_W      = ((2 + 2*IDX_W + DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((PROD_W + 2*IDX_W + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [DIM_W-1:0] cfg_data_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // opcode, elem_row, elem_col, elem_value, zero pad
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // product_value, out_row, out_col, zero pad
  output logic [OUT_W-1:0]      m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = $clog2(MAX_DIM);
  localparam int unsigned ACC_W = 2 * DATA_WIDTH + $clog2(MAX_DIM);

  function automatic logic [DW-1:0] last_idx(input logic [DIM_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_DIM) begin
      r = DW'(MAX_DIM - 1);
    end else begin
      r = DW'(v - DIM_W'(1));
    end
    return r;
  endfunction

  logic [DIM_W-1:0] rows_a_q, inner_len_q, cols_b_q;
  mme_state_e       state_q, state_d;
  logic [DW-1:0]    i_q, j_q, k_q;
  logic [DW-1:0]    last_i, last_j, last_k;
  logic             en, in_acc, out_acc, issue, at_k, at_j, at_i;

  logic [1:0]            in_op;
  logic [IDX_W-1:0]      in_row, in_col;
  logic [DATA_WIDTH-1:0] in_val;
  logic                  load_ok;
  logic [AW-1:0]         waddr, raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] rd_a, rd_b;

  mme_tok_t               bus_tok_q;
  mme_tok_t               tok   [MAX_DIM+1];
  logic signed [ACC_W-1:0] acc  [MAX_DIM+1];

  logic                  out_valid_q, out_last_q;
  logic [IDX_W-1:0]      out_row_q, out_col_q;
  logic [PROD_W-1:0]     out_val_q;

  assign in_op  = s_axis_tdata[1:0];
  assign in_row = s_axis_tdata[2 +: IDX_W];
  assign in_col = s_axis_tdata[2+IDX_W +: IDX_W];
  assign in_val = s_axis_tdata[2+2*IDX_W +: DATA_WIDTH];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign en            = !out_valid_q || m_axis_tready;
  assign issue         = (state_q == ST_ISSUE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_W'(8);
      inner_len_q <= DIM_W'(8);
      cols_b_q    <= DIM_W'(8);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        CFG_INNER_LEN: inner_len_q <= cfg_data_i;
        CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  assign last_i = last_idx(rows_a_q);
  assign last_j = last_idx(cols_b_q);
  assign last_k = last_idx(inner_len_q);
  assign at_k   = (k_q == last_k);
  assign at_j   = (j_q == last_j);
  assign at_i   = (i_q == last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_op == OP_COMPUTE) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (en && at_k && at_j && at_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc && m_axis_tlast) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (state_q == ST_IDLE) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (issue && en) begin
      if (!at_k) begin
        k_q <= k_q + DW'(1);
      end else begin
        k_q <= '0;
        if (!at_j) begin
          j_q <= j_q + DW'(1);
        end else begin
          j_q <= '0;
          i_q <= i_q + DW'(1);
        end
      end
    end
  end

  assign load_ok = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign waddr   = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);
  assign raddr_a = AW'(i_q) * AW'(MAX_DIM) + AW'(k_q);
  assign raddr_b = AW'(k_q) * AW'(MAX_DIM) + AW'(j_q);

  mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (in_acc && load_ok && in_op == OP_LOAD_A),
    .waddr_i (waddr),
    .wdata_i (in_val),
    .re_i    (en),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (in_acc && load_ok && in_op == OP_LOAD_B),
    .waddr_i (waddr),
    .wdata_i (in_val),
    .re_i    (en),
    .raddr_i (raddr_b),
    .rdata_o (rd_b)
  );

  // The tag launches with the first term of each element and is registered
  // alongside the store reads, so it lines up with the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_tok_q <= '0;
    end else if (en) begin
      bus_tok_q.valid <= issue && (k_q == '0);
      bus_tok_q.row   <= IDX_W'(i_q);
      bus_tok_q.col   <= IDX_W'(j_q);
      bus_tok_q.last  <= at_i && at_j;
    end
  end

  assign tok[0] = bus_tok_q;
  assign acc[0] = '0;

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    mme_cell #(.DATA_WIDTH(DATA_WIDTH), .ACC_W(ACC_W)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .active_i (int'(last_k) >= c),
      .a_i      (rd_a),
      .b_i      (rd_b),
      .tok_i    (tok[c]),
      .acc_i    (acc[c]),
      .tok_o    (tok[c+1]),
      .acc_o    (acc[c+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= tok[MAX_DIM].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_val_q  <= PROD_W'(acc[MAX_DIM]);
      out_row_q  <= tok[MAX_DIM].row;
      out_col_q  <= tok[MAX_DIM].col;
      out_last_q <= tok[MAX_DIM].last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OUT_W'({out_col_q, out_row_q, out_val_q});

endmodule
`default_nettype wire

// File: design/mme_checker.sv
`default_nettype none
module mme_checker
  import mme_pkg::*;
#(
  parameter int unsigned OUT_W = 48
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic [1:0]       in_op_i,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic             m_axis_tlast
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_compute_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && in_op_i == OP_COMPUTE |=> !s_axis_tready)
    else $error("input taken during a compute");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("input not released after last result");

  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("result shown while idle");

endmodule

bind matrix_multiply_engine mme_checker #(.OUT_W(OUT_W)) u_mme_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .in_op_i       (s_axis_tdata[1:0]),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
